@@ src/dsbp_pkg.sv @@
// Package with the types, codes and the padding helper function of the dial-string BCD packer.
package dsbp_pkg;

    localparam int CHAR_W  = 8;
    localparam int NIBBLE_W = 4;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 8;
    localparam int FMT_W   = 2;

    typedef enum logic [FMT_W-1:0] {
        FMT_PACKED_LSB = 2'd0,
        FMT_PACKED_MSB = 2'd1,
        FMT_UNPACKED   = 2'd2,
        FMT_RESERVED   = 2'd3
    } t_format;

    localparam logic [NIBBLE_W-1:0] NIB_STAR  = 4'hA;
    localparam logic [NIBBLE_W-1:0] NIB_HASH  = 4'hB;
    localparam logic [NIBBLE_W-1:0] NIB_PAUSE = 4'hC;
    localparam logic [NIBBLE_W-1:0] NIB_WAIT  = 4'hD;
    localparam logic [NIBBLE_W-1:0] NIB_PLUS  = 4'hE;
    localparam logic [NIBBLE_W-1:0] NIB_FILL  = 4'hF;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0]  bcd_byte;
        logic               byte_valid;
        logic               end_of_number;
        logic [COUNT_W-1:0] digit_count;
    } t_result;

    function automatic logic [BYTE_W-1:0] padded(
        input logic [NIBBLE_W-1:0] d,
        input t_format             fmt
    );
        logic [BYTE_W-1:0] b;
        if (fmt == FMT_PACKED_LSB) begin
            b = {NIB_FILL, d};
        end else begin
            b = {d, NIB_FILL};
        end
        return b;
    endfunction

endpackage

@@ src/dsbp_if.sv @@
// Valid/ready channel interfaces for the character input and the BCD result output.
interface dsbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsbp_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dsbp_out_if;
    logic                          valid;
    logic                          ready;
    logic [dsbp_pkg::BYTE_W-1:0]   bcd_byte;
    logic                          byte_valid;
    logic                          end_of_number;
    logic [dsbp_pkg::COUNT_W-1:0]  digit_count;

    modport source (output valid, output bcd_byte, output byte_valid,
                    output end_of_number, output digit_count, input ready);
    modport sink   (input valid, input bcd_byte, input byte_valid,
                    input end_of_number, input digit_count, output ready);
endinterface

@@ src/dsbp_classify.sv @@
// Character classifier that maps one dial-string character to a BCD digit code.
module dsbp_classify (
    input  logic [dsbp_pkg::CHAR_W-1:0]   i_char,
    input  dsbp_pkg::t_format             i_fmt,
    output logic                          o_is_digit,
    output logic [dsbp_pkg::NIBBLE_W-1:0] o_digit
);
    import dsbp_pkg::*;

    logic [CHAR_W-1:0] offset;

    assign offset = i_char - CHAR_W'("0");

    always_comb begin
        o_is_digit = 1'b1;
        o_digit    = '0;
        if (i_char >= CHAR_W'("0") && i_char <= CHAR_W'("9")) begin
            o_digit = offset[NIBBLE_W-1:0];
        end else if (i_char == CHAR_W'("*")) begin
            o_digit = NIB_STAR;
        end else if (i_char == CHAR_W'("#")) begin
            o_digit = NIB_HASH;
        end else if (i_char == CHAR_W'("P") || i_char == CHAR_W'("p")) begin
            o_digit = NIB_PAUSE;
        end else if (i_char == CHAR_W'("W") || i_char == CHAR_W'("w")) begin
            o_digit = NIB_WAIT;
        end else if (i_char == CHAR_W'("+") && i_fmt == FMT_PACKED_LSB) begin
            o_digit = NIB_PLUS;
        end else begin
            o_is_digit = 1'b0;
        end
    end
endmodule

@@ src/dsbp_out_buf.sv @@
// Two-entry result buffer that decouples the packer from the output channel.
module dsbp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dsbp_pkg::t_result i_data,
    output logic              o_full,
    dsbp_out_if.source        o_out
);
    import dsbp_pkg::*;

    t_result     r_mem [2];
    logic        r_wptr, n_wptr;
    logic        r_rptr, n_rptr;
    logic [1:0]  r_count, n_count;
    logic        pop;
    t_result     head;

    assign pop    = o_out.valid && o_out.ready;
    assign o_full = (r_count == 2'd2);
    assign head   = r_mem[r_rptr];

    assign o_out.valid         = (r_count != 2'd0);
    assign o_out.bcd_byte      = head.bcd_byte;
    assign o_out.byte_valid    = head.byte_valid;
    assign o_out.end_of_number = head.end_of_number;
    assign o_out.digit_count   = head.digit_count;

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("Result buffer count out of range.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("Push into a full result buffer.");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("Result buffer pointers disagree with count.");
endmodule

@@ src/dial_string_to_bcd_packer_core.sv @@
// Top level of the dial-string to BCD packer: digit pairing state and result emission.
// Each result is written into the registered output buffer when its input word is accepted.
// Throughput: one input word per cycle, sustained while the output side takes results.
// The rate is set by the single classify-and-pair step and the two-entry output buffer.
// Reset: synchronous, active low; clears the pairing state, the digit count, the
// output buffer and sets the format register to packed low nibble first.
module dial_string_to_bcd_packer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dsbp_pkg::FMT_W-1:0]  i_cfg_wdata,
    dsbp_in_if.sink                     i_char,
    dsbp_out_if.source                  o_bcd
);
    import dsbp_pkg::*;

    t_format              r_fmt;
    logic [NIBBLE_W-1:0]  r_held, n_held;
    logic                 r_waiting, n_waiting;
    logic                 r_stopped, n_stopped;
    logic [COUNT_W-1:0]   r_count, n_count;

    logic                 accept;
    logic                 last;
    logic                 packed_fmt;
    logic                 active;
    logic                 is_digit;
    logic [NIBBLE_W-1:0]  digit;
    logic [COUNT_W-1:0]   count_inc;
    logic                 buf_full;
    logic                 push;
    t_result              result;

    assign i_char.ready = !buf_full;
    assign accept       = i_char.valid && i_char.ready;
    assign last         = i_char.last_char;
    assign packed_fmt   = (r_fmt == FMT_PACKED_LSB) || (r_fmt == FMT_PACKED_MSB);
    assign active       = !r_stopped && (r_fmt != FMT_RESERVED);
    assign count_inc    = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);

    dsbp_classify u_classify (
        .i_char     (i_char.char_code),
        .i_fmt      (r_fmt),
        .o_is_digit (is_digit),
        .o_digit    (digit)
    );

    always_comb begin
        n_held    = r_held;
        n_waiting = r_waiting;
        n_stopped = r_stopped;
        n_count   = r_count;
        push      = 1'b0;
        result    = '0;
        if (accept) begin
            if (active) begin
                if (!is_digit) begin
                    n_stopped = 1'b1;
                    if (packed_fmt && r_waiting) begin
                        push              = 1'b1;
                        result.byte_valid = 1'b1;
                        result.bcd_byte   = padded(r_held, r_fmt);
                        n_waiting         = 1'b0;
                    end
                end else begin
                    n_count = count_inc;
                    if (!packed_fmt) begin
                        push              = 1'b1;
                        result.byte_valid = 1'b1;
                        result.bcd_byte   = {{(BYTE_W-NIBBLE_W){1'b0}}, digit};
                    end else if (r_waiting) begin
                        push              = 1'b1;
                        result.byte_valid = 1'b1;
                        if (r_fmt == FMT_PACKED_LSB) begin
                            result.bcd_byte = {digit, r_held};
                        end else begin
                            result.bcd_byte = {r_held, digit};
                        end
                        n_waiting = 1'b0;
                    end else if (last) begin
                        push              = 1'b1;
                        result.byte_valid = 1'b1;
                        result.bcd_byte   = padded(digit, r_fmt);
                    end else begin
                        n_held    = digit;
                        n_waiting = 1'b1;
                    end
                end
            end
            result.digit_count   = n_count;
            result.end_of_number = last;
            if (last) begin
                push      = 1'b1;
                n_held    = '0;
                n_waiting = 1'b0;
                n_stopped = 1'b0;
                n_count   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_PACKED_LSB;
            r_held    <= '0;
            r_waiting <= 1'b0;
            r_stopped <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= t_format'(i_cfg_wdata);
            end
            r_held    <= n_held;
            r_waiting <= n_waiting;
            r_stopped <= n_stopped;
            r_count   <= n_count;
        end
    end

    dsbp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_full  (buf_full),
        .o_out   (o_bcd)
    );

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |-> push)
        else $error("End of string word produced no result.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_count == '0 && !r_waiting && !r_stopped))
        else $error("String state not cleared after end of string.");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_stopped && !last) |-> !push)
        else $error("Result produced after conversion stopped.");

    a_waiting_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> (r_count != '0))
        else $error("Held digit without a digit count.");
endmodule

@@ tb/tb_dial_string_to_bcd_packer_core.sv @@
// Self-checking testbench for the dial-string to BCD packer, checked against a behavioral predictor.
module tb_dial_string_to_bcd_packer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dsbp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_MISMATCHES = 10;

    logic clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [FMT_W-1:0] i_cfg_wdata;

    dsbp_in_if  char_if ();
    dsbp_out_if bcd_if ();

    dial_string_to_bcd_packer_core dut (
        .i_clk       (clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (char_if),
        .o_bcd       (bcd_if)
    );

    always #5 clk = ~clk;

    t_format            fmt_model;
    logic [NIBBLE_W-1:0] held_model;
    logic               waiting_model;
    logic               stopped_model;
    logic [COUNT_W-1:0] count_model;
    t_result            pending_bcd[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    logic gaps_off = 1'b0;
    int hold_cycles_req = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_tick = 0;
    t_result got_word;
    t_result want_word;

    function automatic logic [4:0] dial_nibble(input logic [CHAR_W-1:0] code, input t_format f);
        logic [4:0] n;
        n = {1'b1, 4'h0};
        if (code >= "0" && code <= "9") begin
            n = {1'b0, code[3:0]};
        end else if (code == "*") begin
            n = {1'b0, NIB_STAR};
        end else if (code == "#") begin
            n = {1'b0, NIB_HASH};
        end else if (code == "P" || code == "p") begin
            n = {1'b0, NIB_PAUSE};
        end else if (code == "W" || code == "w") begin
            n = {1'b0, NIB_WAIT};
        end else if (code == "+" && f == FMT_PACKED_LSB) begin
            n = {1'b0, NIB_PLUS};
        end
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] odd_digit_byte(input logic [NIBBLE_W-1:0] d,
                                                         input t_format f);
        return (f == FMT_PACKED_LSB) ? {NIB_FILL, d} : {d, NIB_FILL};
    endfunction

    task automatic pack_dial_char(input logic [CHAR_W-1:0] code, input logic is_last);
        t_result r;
        logic emit;
        logic fmt_paired;
        logic [4:0] cls;
        r = '0;
        emit = is_last;
        fmt_paired = (fmt_model == FMT_PACKED_LSB) || (fmt_model == FMT_PACKED_MSB);
        if (!stopped_model && fmt_model != FMT_RESERVED) begin
            cls = dial_nibble(code, fmt_model);
            if (cls[4]) begin
                stopped_model = 1'b1;
                if (fmt_paired && waiting_model) begin
                    emit = 1'b1;
                    r.byte_valid = 1'b1;
                    r.bcd_byte = odd_digit_byte(held_model, fmt_model);
                    waiting_model = 1'b0;
                end
            end else begin
                if (count_model != COUNT_MAX) begin
                    count_model = count_model + 1'b1;
                end
                if (!fmt_paired) begin
                    emit = 1'b1;
                    r.byte_valid = 1'b1;
                    r.bcd_byte = {4'h0, cls[3:0]};
                end else if (waiting_model) begin
                    emit = 1'b1;
                    r.byte_valid = 1'b1;
                    r.bcd_byte = (fmt_model == FMT_PACKED_LSB) ? {cls[3:0], held_model}
                                                               : {held_model, cls[3:0]};
                    waiting_model = 1'b0;
                end else if (is_last) begin
                    emit = 1'b1;
                    r.byte_valid = 1'b1;
                    r.bcd_byte = odd_digit_byte(cls[3:0], fmt_model);
                end else begin
                    held_model = cls[3:0];
                    waiting_model = 1'b1;
                end
            end
        end
        if (emit) begin
            r.end_of_number = is_last;
            r.digit_count = count_model;
            pending_bcd.push_back(r);
        end
        if (is_last) begin
            held_model = '0;
            waiting_model = 1'b0;
            stopped_model = 1'b0;
            count_model = '0;
        end
    endtask

    task automatic send_word(input logic [CHAR_W-1:0] code, input logic is_last);
        int gap;
        if (!gaps_off && burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge clk);
                char_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge clk);
        char_if.valid <= 1'b1;
        char_if.char_code <= code;
        char_if.last_char <= is_last;
        do @(posedge clk); while (!char_if.ready);
        pack_dial_char(code, is_last);
    endtask

    task automatic send_string(input string s, input logic close);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], close && (i == s.len() - 1));
        end
    endtask

    function automatic logic [CHAR_W-1:0] rand_dial_char(input logic allow_any);
        string specials;
        int pick;
        specials = "*#PpWw+";
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return CHAR_W'("0" + $urandom_range(0, 9));
        end else if (pick < 80) begin
            return specials[$urandom_range(0, allow_any ? 6 : 5)];
        end else if (allow_any) begin
            return CHAR_W'($urandom_range(0, 255));
        end
        return CHAR_W'("0" + $urandom_range(0, 9));
    endfunction

    task automatic send_random_string(input int len, input logic close, input logic allow_any);
        for (int i = 0; i < len; i++) begin
            send_word(rand_dial_char(allow_any), close && (i == len - 1));
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        char_if.valid <= 1'b0;
        while (pending_bcd.size() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_format(input t_format f);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= f;
        @(negedge clk);
        i_cfg_we <= 1'b0;
        fmt_model = f;
    endtask

    task automatic test_packed_lsb_mix();
        send_string("9*+#0", 1'b1);
        drain_results();
    endtask

    task automatic test_packed_msb_stop();
        write_format(FMT_PACKED_MSB);
        send_string("Pw5", 1'b0);
        send_word(8'hFF, 1'b0);
        send_string("37", 1'b1);
        send_string("+", 1'b1);
        drain_results();
    endtask

    task automatic test_unpacked_and_reserved();
        write_format(FMT_UNPACKED);
        send_string("Wp8", 1'b0);
        send_word(8'h00, 1'b0);
        send_string("9", 1'b1);
        write_format(FMT_RESERVED);
        send_string("12", 1'b1);
        drain_results();
    endtask

    task automatic test_format_switch_midstring();
        write_format(FMT_PACKED_LSB);
        send_string("4", 1'b0);
        write_format(FMT_UNPACKED);
        send_string("6", 1'b0);
        write_format(FMT_PACKED_LSB);
        send_string("7", 1'b1);
        drain_results();
    endtask

    task automatic test_output_hold();
        write_format(FMT_UNPACKED);
        gaps_off = 1'b1;
        hold_cycles_req = 80;
        send_random_string(16, 1'b1, 1'b0);
        gaps_off = 1'b0;
        drain_results();
    endtask

    task automatic test_count_saturation();
        write_format(FMT_PACKED_MSB);
        send_random_string(257, 1'b1, 1'b0);
        drain_results();
    endtask

    task automatic test_random_strings();
        t_format phase_fmt [6];
        int sent;
        int len;
        phase_fmt = '{FMT_UNPACKED, FMT_PACKED_LSB, FMT_RESERVED, FMT_PACKED_MSB,
                      FMT_PACKED_LSB, FMT_PACKED_MSB};
        for (int p = 0; p < 6; p++) begin
            write_format(phase_fmt[p]);
            gaps_off = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 28) begin
                len = $urandom_range(1, 12);
                send_random_string(len, 1'b1, 1'b1);
                sent += len;
            end
            if ($urandom_range(0, 1) == 1) begin
                send_random_string($urandom_range(1, 3), 1'b0, 1'b1);
            end
            gaps_off = 1'b0;
        end
        drain_results();
    endtask

    always @(negedge clk) begin
        stall_tick++;
        if (stall_tick % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        if (hold_cycles_req > 0) begin
            hold_left = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            bcd_if.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: bcd_if.ready <= 1'b1;
                1: bcd_if.ready <= 1'($urandom_range(0, 1));
                2: bcd_if.ready <= (stall_tick % 3 == 0);
                default: bcd_if.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (i_rst_n && bcd_if.valid && bcd_if.ready) begin
            got_word = {bcd_if.bcd_byte, bcd_if.byte_valid, bcd_if.end_of_number,
                        bcd_if.digit_count};
            if (pending_bcd.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MISMATCHES) begin
                    $display("unexpected word: byte=%02h vld=%0b eon=%0b cnt=%0d",
                             got_word.bcd_byte, got_word.byte_valid,
                             got_word.end_of_number, got_word.digit_count);
                end
            end else begin
                want_word = pending_bcd.pop_front();
                if (got_word !== want_word) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES) begin
                        $display({"mismatch: expected byte=%02h vld=%0b eon=%0b cnt=%0d,",
                                  " got byte=%02h vld=%0b eon=%0b cnt=%0d"},
                                 want_word.bcd_byte, want_word.byte_valid,
                                 want_word.end_of_number, want_word.digit_count,
                                 got_word.bcd_byte, got_word.byte_valid,
                                 got_word.end_of_number, got_word.digit_count);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = FMT_PACKED_LSB;
        char_if.valid = 1'b0;
        char_if.char_code = '0;
        char_if.last_char = 1'b0;
        bcd_if.ready = 1'b0;
        fmt_model = FMT_PACKED_LSB;
        held_model = '0;
        waiting_model = 1'b0;
        stopped_model = 1'b0;
        count_model = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        i_rst_n <= 1'b1;

        test_packed_lsb_mix();
        test_packed_msb_stop();
        test_unpacked_and_reserved();
        test_format_switch_midstring();
        test_output_hold();
        test_random_strings();
        test_count_saturation();

        drain_results();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && pending_bcd.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
